>>> design/magic_length_frame_deframer_core_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_CORE_MACROS_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MLFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MLFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MLFD_ASSERT(label, clk, rst_n, prop, msg)
`define MLFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/mlfd_pkg.sv
// shared types and constants of the magic/length frame deframer
// no dependencies
package mlfd_pkg;

    localparam int HDR_BYTES = 20;
    localparam int FILL_W    = $clog2(HDR_BYTES);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int TDATA_W   = 144;

    localparam logic [31:0] LEN_MIN           = 32'd20;
    localparam logic [15:0] MAGIC_RESET       = 16'hC1EB;
    localparam logic [7:0]  VERSION_RESET     = 8'd1;
    localparam logic [31:0] MAX_LEN_RESET     = 32'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

    localparam logic ITEM_HEADER = 1'b0;
    localparam logic ITEM_BODY   = 1'b1;

    typedef struct packed {
        logic [31:0] frame_len;
        logic [63:0] request_id;
        logic [15:0] method_id;
        logic [15:0] module_id;
        logic [7:0]  frame_kind;
    } hdr_t;

endpackage

>>> design/mlfd_cell.sv
// one byte cell of the header window shift chain
// depends on nothing
module mlfd_cell
(
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= d;
        end
    end

    assign q = byte_reg;

endmodule

>>> design/mlfd_window.sv
// 20-byte header window built from a chain of cells, plus the header check
// depends on mlfd_pkg and mlfd_cell
module mlfd_window
    import mlfd_pkg::*;
(
    input  logic        clk,
    input  logic        shift,
    input  logic [7:0]  in_byte,
    input  logic [15:0] magic_word,
    input  logic [7:0]  expected_version,
    input  logic [31:0] max_frame_len,
    output logic        hdr_ok,
    output hdr_t        hdr
);

    logic [7:0] q    [HDR_BYTES-1];
    logic [7:0] view [HDR_BYTES];

    // newest byte enters at the top cell, oldest leaves from cell 0
    for (genvar i = 0; i < HDR_BYTES - 1; i++)
    begin : g_cell
        if (i == HDR_BYTES - 2)
        begin : g_top
            mlfd_cell u_cell (.clk(clk), .shift(shift), .d(in_byte), .q(q[i]));
        end
        else
        begin : g_mid
            mlfd_cell u_cell (.clk(clk), .shift(shift), .d(q[i+1]), .q(q[i]));
        end
        assign view[i] = q[i];
    end

    // the incoming byte completes the window
    assign view[HDR_BYTES-1] = in_byte;

    // check is made on the window as it stands once the incoming byte is in
    always_comb
    begin
        hdr.frame_kind = view[3];
        hdr.module_id  = {view[4], view[5]};
        hdr.method_id  = {view[6], view[7]};
        hdr.request_id = {view[8], view[9], view[10], view[11],
                          view[12], view[13], view[14], view[15]};
        hdr.frame_len  = {view[16], view[17], view[18], view[19]};
        hdr_ok = (view[0] == magic_word[15:8]) && (view[1] == magic_word[7:0])
              && (view[2] == expected_version)
              && (hdr.frame_len >= LEN_MIN) && (hdr.frame_len <= max_frame_len);
    end

endmodule

>>> design/magic_length_frame_deframer_core.sv
// a header transfer appears in the cycle after the byte that completes it, a body
// byte in the cycle after it is taken; one byte per cycle sustained while m_tready
// drains the output; rate is set by the window compare and the output register
// rst_n (async, active low) clears control state and restores register defaults;
// window bytes are not cleared, the fill count hides them
module magic_length_frame_deframer_core
    import mlfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // byte stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    // frame items out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] frame_kind, [23:8] module_id, [39:24] method_id,
    // [103:40] request_id, [135:104] frame_len, [143:136] body_byte
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tuser,   // item_type
    output logic                 m_tlast    // last_of_frame
);

`include "magic_length_frame_deframer_core_macros.svh"

    // configuration registers
    logic [15:0] magic_reg;
    logic [7:0]  version_reg;
    logic [31:0] max_len_reg;

    // control state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              in_body_reg, in_body_next;
    logic [31:0]       body_rem_reg, body_rem_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic               out_type_reg, out_type_next;
    logic               out_last_reg, out_last_next;

    logic        take;
    logic        shift;
    logic        window_full;
    logic        hdr_ok;
    hdr_t        hdr;
    logic [31:0] hdr_body_len;

    // the output slot is free or being emptied in this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    // bytes only enter the window while hunting
    assign shift    = take && !in_body_reg;
    assign window_full  = (fill_reg == FILL_W'(HDR_BYTES - 1));
    assign hdr_body_len = hdr.frame_len - LEN_MIN;

    mlfd_window u_window
    (
        .clk              (clk),
        .shift            (shift),
        .in_byte          (s_tdata),
        .magic_word       (magic_reg),
        .expected_version (version_reg),
        .max_frame_len    (max_len_reg),
        .hdr_ok           (hdr_ok),
        .hdr              (hdr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_RESET;
            version_reg <= VERSION_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAGIC:   magic_reg   <= cfg_wdata[15:0];
                CFG_VERSION: version_reg <= cfg_wdata[7:0];
                CFG_MAX_LEN: max_len_reg <= cfg_wdata;
                default:     ;  // unused index, write dropped
            endcase
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        in_body_next   = in_body_reg;
        body_rem_next  = body_rem_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_type_next  = out_type_reg;
        out_last_next  = out_last_reg;

        if (take)
        begin
            if (in_body_reg)
            begin
                // body byte passes straight through
                out_valid_next = 1'b1;
                out_type_next  = ITEM_BODY;
                out_data_next  = {s_tdata, (TDATA_W - 8)'(0)};
                if (body_rem_reg <= 32'd1)
                begin
                    out_last_next = 1'b1;
                    body_rem_next = '0;
                    in_body_next  = 1'b0;
                end
                else
                begin
                    out_last_next = 1'b0;
                    body_rem_next = body_rem_reg - 32'd1;
                end
            end
            else if (!window_full)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            else if (hdr_ok)
            begin
                // header found, restart the window after the body
                out_valid_next = 1'b1;
                out_type_next  = ITEM_HEADER;
                out_data_next  = {8'd0, hdr.frame_len, hdr.request_id, hdr.method_id,
                                  hdr.module_id, hdr.frame_kind};
                out_last_next  = (hdr_body_len == '0);
                body_rem_next  = hdr_body_len;
                in_body_next   = (hdr_body_len != '0);
                fill_next      = '0;
            end
            // rejected candidate: oldest byte already slid out, fill stays full-1
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            in_body_reg   <= 1'b0;
            body_rem_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            in_body_reg   <= in_body_next;
            body_rem_reg  <= body_rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_type_reg <= out_type_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_type_reg;
    assign m_tlast  = out_last_reg;

    `MLFD_ASSERT(a_fill_range, clk, rst_n, fill_reg <= FILL_W'(HDR_BYTES - 1), "fill out of range")
    `MLFD_ASSERT_IMPL(a_body_rem, clk, rst_n, in_body_reg, body_rem_reg != '0, "empty body count")
    `MLFD_ASSERT_IMPL(a_body_fill, clk, rst_n, in_body_reg, fill_reg == '0, "window fill in body")
    `MLFD_ASSERT_IMPL(a_hdr_open, clk, rst_n,
        out_valid_reg && (out_type_reg == ITEM_HEADER) && !out_last_reg, in_body_reg,
        "open header without body state")

endmodule

>>> tb/testbench.sv
// self-checking testbench for magic_length_frame_deframer_core: byte stream in, frame items out
// depends on mlfd_pkg (design/mlfd_pkg.sv) and the deframer rtl
// a scoreboard class predicts header and body transfers and checks them field by field
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfd_pkg::*;

    // register index outside the map, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     TAIL_CYCLES   = 10;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint CYCLE_LIMIT   = 1000000;

    // one expected transfer on the frame side
    typedef struct packed {
        logic       item_type;
        hdr_t       hdr;
        logic [7:0] body_byte;
        logic       last;
    } frame_item_t;

    // deframer predictor and checker of the output transfers
    class deframer_scoreboard;
        bit [15:0]   magic;
        bit [7:0]    version;
        bit [31:0]   max_len;
        bit [7:0]    window[HDR_BYTES];
        int unsigned fill;
        bit          in_body;
        bit [31:0]   body_left;
        frame_item_t expected_items[$];
        int unsigned mismatches;

        function new();
            magic      = MAGIC_RESET;
            version    = VERSION_RESET;
            max_len    = MAX_LEN_RESET;
            fill       = 0;
            in_body    = 1'b0;
            body_left  = '0;
            mismatches = 0;
            foreach (window[i])
            begin
                window[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            unique case (idx)
                CFG_MAGIC:   magic   = data[15:0];
                CFG_VERSION: version = data[7:0];
                CFG_MAX_LEN: max_len = data;
                default:     ;
            endcase
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        // append one transfer to the tail of the expectation queue
        function void add_expected(frame_item_t item);
            expected_items.insert(expected_items.size(), item);
        endfunction

        // note one accepted stream byte, queue the transfer it causes if any
        function void take_byte(bit [7:0] b);
            frame_item_t item;
            bit [31:0]   len;
            int          i;
            item = '0;
            if (in_body)
            begin
                item.item_type = ITEM_BODY;
                item.body_byte = b;
                item.last      = (body_left <= 1);
                if (body_left <= 1)
                begin
                    body_left = '0;
                    in_body   = 1'b0;
                end
                else
                begin
                    body_left--;
                end
                add_expected(item);
                return;
            end
            if (fill >= HDR_BYTES)
                fill = HDR_BYTES - 1;
            window[fill] = b;
            fill++;
            if (fill < HDR_BYTES)
                return;
            // length sits big-endian in the last four header bytes
            len = {window[16], window[17], window[18], window[19]};
            if (window[0] != magic[15:8] || window[1] != magic[7:0] ||
                window[2] != version || len < LEN_MIN || len > max_len)
            begin
                for (i = 0; i < HDR_BYTES - 1; i++)
                begin
                    window[i] = window[i+1];
                end
                window[HDR_BYTES-1] = '0;
                fill = HDR_BYTES - 1;
                return;
            end
            item.item_type      = ITEM_HEADER;
            item.hdr.frame_kind = window[3];
            item.hdr.module_id  = {window[4], window[5]};
            item.hdr.method_id  = {window[6], window[7]};
            item.hdr.request_id = {window[8], window[9], window[10], window[11],
                                   window[12], window[13], window[14], window[15]};
            item.hdr.frame_len  = len;
            item.last           = (len == LEN_MIN);
            body_left           = len - LEN_MIN;
            in_body             = (body_left != 0);
            fill                = 0;
            add_expected(item);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%s mismatch: expected %0h, got %0h", field, want, got);
            end
        endfunction

        // check one accepted output transfer against the oldest expectation
        function void check_item(logic [TDATA_W-1:0] data, logic user, logic last);
            frame_item_t want;
            hdr_t        got;
            if (expected_items.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected transfer: tdata %h tuser %b tlast %b",
                             data, user, last);
                return;
            end
            want = expected_items.pop_front();
            got  = data[$bits(hdr_t)-1:0];
            compare_field("item_type", want.item_type, user);
            compare_field("frame_kind", want.hdr.frame_kind, got.frame_kind);
            compare_field("module_id", want.hdr.module_id, got.module_id);
            compare_field("method_id", want.hdr.method_id, got.method_id);
            compare_field("request_id", want.hdr.request_id, got.request_id);
            compare_field("frame_len", want.hdr.frame_len, got.frame_len);
            compare_field("body_byte", want.body_byte, data[$bits(hdr_t) +: 8]);
            compare_field("last_of_frame", want.last, last);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] data_byte
    logic                 m_tvalid;
    logic                 m_tready;
    // [7:0] frame_kind, [23:8] module_id, [39:24] method_id,
    // [103:40] request_id, [135:104] frame_len, [143:136] body_byte
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;   // item_type
    logic                 m_tlast;   // last_of_frame

    deframer_scoreboard sb = new();

    // bytes waiting to be offered on the stream side
    bit [7:0] outgoing[$];

    // idle pattern state: a calm stretch means no gaps at all
    bit     send_calm = 1'b0;
    bit     recv_calm = 1'b0;
    bit     hold_req  = 1'b0;
    longint cycles    = 0;

    magic_length_frame_deframer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int idle_cycles(inout bit calm);
        int r;
        if ($urandom_range(0, 99) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic hdr_t random_hdr();
        hdr_t h;
        h.frame_kind = 8'($urandom);
        h.module_id  = 16'($urandom);
        h.method_id  = 16'($urandom);
        h.request_id = {$urandom, $urandom};
        h.frame_len  = LEN_MIN;
        return h;
    endfunction

    // append one byte to the tail of the stream-side queue
    function automatic void queue_byte(bit [7:0] b);
        outgoing.insert(outgoing.size(), b);
    endfunction

    // header bytes in wire order, multi-byte fields big-endian
    function automatic void add_header(bit [15:0] mg, bit [7:0] ver, hdr_t h);
        int i;
        queue_byte(mg[15:8]);
        queue_byte(mg[7:0]);
        queue_byte(ver);
        queue_byte(h.frame_kind);
        for (i = 1; i >= 0; i--)
            queue_byte(h.module_id[8*i +: 8]);
        for (i = 1; i >= 0; i--)
            queue_byte(h.method_id[8*i +: 8]);
        for (i = 7; i >= 0; i--)
            queue_byte(h.request_id[8*i +: 8]);
        for (i = 3; i >= 0; i--)
            queue_byte(h.frame_len[8*i +: 8]);
    endfunction

    function automatic void add_noise(int n);
        repeat (n) queue_byte(8'($urandom));
    endfunction

    // offer one byte, entered and left at a falling edge
    task automatic send_byte(input bit [7:0] b);
        int gap;
        gap = idle_cycles(send_calm);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_byte(b);
        @(negedge clk);
    endtask

    task automatic send_all();
        while (outgoing.size() != 0)
            send_byte(outgoing.pop_front());
    endtask

    // stop offering until every expected transfer is out, then let the window
    // compare of the last byte settle before anything else happens
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // mostly well-formed frames with random content, the rest noise and
    // broken headers; cut headers only where a bogus length stays short
    task automatic random_frames(input int target, input bit allow_cut);
        int          sent;
        int          r;
        int          body;
        longint      room;
        longint      over;
        hdr_t        h;
        sent = 0;
        while (sent < target)
        begin
            h    = random_hdr();
            r    = $urandom_range(0, 99);
            room = (sb.max_len >= LEN_MIN) ? longint'(sb.max_len) - LEN_MIN : 0;
            body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
            if (body > room)
                body = int'(room);
            h.frame_len = LEN_MIN + body;
            if (r < 70)
                add_header(sb.magic, sb.version, h);
            else if (r < 78)
                body = $urandom_range(1, 5);
            else if (r < 84)
                add_header(sb.magic ^ (16'h1 << $urandom_range(0, 15)), sb.version, h);
            else if (r < 89)
                add_header(sb.magic, sb.version ^ (8'h1 << $urandom_range(0, 7)), h);
            else if (r < 93 || (r < 96 && sb.max_len == '1))
            begin
                h.frame_len = $urandom_range(0, LEN_MIN - 1);
                add_header(sb.magic, sb.version, h);
            end
            else if (r < 96)
            begin
                over = longint'(sb.max_len) + 1 + $urandom_range(0, 100);
                if (over > 64'hFFFF_FFFF)
                    over = 64'hFFFF_FFFF;
                h.frame_len = over[31:0];
                add_header(sb.magic, sb.version, h);
            end
            else if (allow_cut)
            begin
                // header broken off part way, hunting has to realign
                add_header(sb.magic, sb.version, h);
                repeat ($urandom_range(1, HDR_BYTES - 1)) void'(outgoing.pop_back());
                body = 0;
            end
            else
                add_header(sb.magic, sb.version, h);
            add_noise(body);
            sent += outgoing.size();
            send_all();
        end
    endtask

    // receiver: random back-pressure, plus one long hold on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready = 1'b1;
            end
            else
            begin
                gap = idle_cycles(recv_calm);
                if (gap > 0)
                begin
                    m_tready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                m_tready = 1'b1;
            end
        end
    end

    // every transfer on the frame side goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_item(m_tdata, m_tuser, m_tlast);
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        hdr_t h;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset register values: empty-body frame with all-ones fields but a zero method_id
        h.frame_kind = 8'hFF;
        h.module_id  = 16'hFFFF;
        h.method_id  = 16'h0000;
        h.request_id = '1;
        h.frame_len  = LEN_MIN;
        add_header(MAGIC_RESET, VERSION_RESET, h);
        // short body carrying the byte extremes
        h.frame_kind = 8'h00;
        h.module_id  = 16'h0000;
        h.method_id  = 16'hFFFF;
        h.request_id = '0;
        h.frame_len  = LEN_MIN + 3;
        add_header(MAGIC_RESET, VERSION_RESET, h);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h5A);
        // stray bytes, one of them the first magic byte
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(MAGIC_RESET[15:8]);
        // wrong version, length below a header, length above the maximum
        h.method_id = 16'h0000;
        add_header(MAGIC_RESET, VERSION_RESET + 8'd1, h);
        h.frame_len = LEN_MIN - 1;
        add_header(MAGIC_RESET, VERSION_RESET, h);
        h.frame_len = MAX_LEN_RESET + 1;
        add_header(MAGIC_RESET, VERSION_RESET, h);
        // header broken off, then a good frame with a one-byte body
        add_header(MAGIC_RESET, VERSION_RESET, h);
        repeat (8) void'(outgoing.pop_back());
        h.frame_len = LEN_MIN + 1;
        add_header(MAGIC_RESET, VERSION_RESET, h);
        queue_byte(8'hA5);
        send_all();

        random_frames(300, 1'b0);
        // long receiver stall while bytes keep coming: the block has to back up
        hold_req = 1'b1;
        random_frames(300, 1'b0);

        // leave a frame half way through its body across the register change
        h = random_hdr();
        h.frame_len = LEN_MIN + 4;
        add_header(sb.magic, sb.version, h);
        add_noise(2);
        send_all();
        drain();

        // all-zero magic, all-ones version, only empty-body frames fit;
        // upper bits of the narrow registers carry junk that must be dropped
        write_reg(CFG_MAGIC, {16'($urandom), 16'h0000});
        write_reg(CFG_VERSION, {24'($urandom), 8'hFF});
        write_reg(CFG_MAX_LEN, LEN_MIN);
        write_reg(CFG_SPARE, $urandom);
        add_noise(2);
        send_all();
        random_frames(300, 1'b1);
        drain();

        // all-ones magic, version zero, no upper length bound
        write_reg(CFG_MAGIC, 32'h0000_FFFF);
        write_reg(CFG_VERSION, 32'h0000_0000);
        write_reg(CFG_MAX_LEN, 32'hFFFF_FFFF);
        random_frames(300, 1'b0);
        drain();

        // maximum below a header: nothing may pass
        write_reg(CFG_MAX_LEN, LEN_MIN - 1);
        random_frames(80, 1'b1);
        drain();

        // random magic and version, small maximum
        write_reg(CFG_MAGIC, $urandom);
        write_reg(CFG_VERSION, $urandom);
        write_reg(CFG_MAX_LEN, LEN_MIN + $urandom_range(0, 60));
        random_frames(450, 1'b1);

        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/mlfd_pkg.sv
design/mlfd_cell.sv
design/mlfd_window.sv
design/magic_length_frame_deframer_core.sv
tb/testbench.sv
